[rtl/bpcg_pkg.sv]
// Shared constants, register codes and the quarter-wave sine builder for the pulse color block.
`timescale 1ns / 1ps

package bpcg_pkg;

  // Configuration port shape
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Register codes, in port index order
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOWER_FIRST = 3'd0,
    REG_LOWER_LAST  = 3'd1,
    REG_UPPER_FIRST = 3'd2,
    REG_UPPER_LAST  = 3'd3,
    REG_SPAN        = 3'd4,
    REG_OFFSET      = 3'd5,
    REG_STEP        = 3'd6
  } cfg_reg_t;

  // Field widths fixed by the register map
  localparam int RGB_W    = 24;
  localparam int SPAN_W   = 20;
  localparam int OFFSET_W = 20;
  localparam int PHASE_W  = 24;
  localparam int CHAN_W   = 8;
  localparam int SINE_W   = 15;

  // Reset values
  localparam logic [RGB_W-1:0]    RST_LOWER_RGB = 24'h000000;
  localparam logic [RGB_W-1:0]    RST_UPPER_RGB = 24'hFFFFFF;
  localparam logic [SPAN_W-1:0]   RST_SPAN      = 20'd1000;
  localparam logic [OFFSET_W-1:0] RST_OFFSET    = 20'd0;
  localparam logic [PHASE_W-1:0]  RST_STEP      = 24'd65536;

  // Pipeline map: input register, one quotient bit per stage, then blend, mix, output
  localparam int FRAC_BITS  = 16;
  localparam int ST_IN      = 0;
  localparam int ST_DIV_END = FRAC_BITS;
  localparam int ST_BOUND   = ST_DIV_END + 1;
  localparam int ST_MIX     = ST_BOUND + 1;
  localparam int ST_OUT     = ST_MIX + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Quarter-wave entry i of a table with 2^b steps, unsigned Q0.15, from a Q30 Taylor series
  function automatic logic [SINE_W-1:0] sine_entry(input logic [31:0] i, input int b);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x    = ({32'd0, i} * HALF_PI_Q30) >> b;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
    r = (sum + 64'd16384) >> 15;
    return (r > 64'd32767) ? 15'd32767 : r[SINE_W-1:0];
  endfunction

endpackage

[rtl/bpcg_ifs.sv]
// Valid/ready channel interfaces for the time input and the color output.
`timescale 1ns / 1ps

interface bpcg_time_if #(
  parameter int TIME_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] time_ticks;

  modport source (output valid, output time_ticks, input ready);
  modport sink   (input valid, input time_ticks, output ready);
endinterface

interface bpcg_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

[rtl/bpcg_sine_rom.sv]
// Quarter-wave sine ROM with registered read.
`timescale 1ns / 1ps

module bpcg_sine_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [TABLE_BITS:0]           addr,
  output logic [bpcg_pkg::SINE_W-1:0]   data
);

  localparam int DEPTH = (1 << TABLE_BITS) + 1;

  logic [bpcg_pkg::SINE_W-1:0] rom [DEPTH];

  // Fill the table from the series at elaboration
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_entry
    assign rom[gi] = bpcg_pkg::sine_entry(32'(gi), TABLE_BITS);
  end

  // Read and hold while the stage is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data <= rom[addr];
    end
  end

endmodule

[rtl/bounded_pulse_color_generator.sv]
// Top level: pipelined bounded pulse color generator with its register file.
// A time beat accepted at an edge loads the input register, then moves through the divider,
// bound and mix stages into the output register; the color beat leaves when the sink is ready.
// Throughput: one beat per cycle while the sink is ready; a 20-stage pipeline with a 16-stage
// one-bit-per-stage divider for time/span and a 24x24 phase multiply in stage 1.
// Stalls collapse bubbles stage by stage; input ready falls only when every stage holds a beat.
// Reset (synchronous, rst high) clears all valid bits and loads the register reset values.
`timescale 1ns / 1ps

module bounded_pulse_color_generator #(
  parameter int TIME_BITS       = 20,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bpcg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bpcg_pkg::CFG_DATA_W-1:0]    cfg_data,
  bpcg_time_if.sink                          time_in,
  bpcg_rgb_if.source                         color_out
);

  localparam int NS      = bpcg_pkg::NUM_STAGES;
  localparam int DIV_END = bpcg_pkg::ST_DIV_END;
  localparam int SPAN_W  = bpcg_pkg::SPAN_W;
  localparam int PH_W    = bpcg_pkg::PHASE_W;
  localparam int SW      = bpcg_pkg::SINE_W;
  localparam int AW      = SINE_TABLE_BITS + 1;
  localparam int WIDE_W  = TIME_BITS + 32;
  localparam int FULL    = 1 << SINE_TABLE_BITS;

  // Configuration registers
  logic [bpcg_pkg::RGB_W-1:0]    lower_first_rgb;
  logic [bpcg_pkg::RGB_W-1:0]    lower_last_rgb;
  logic [bpcg_pkg::RGB_W-1:0]    upper_first_rgb;
  logic [bpcg_pkg::RGB_W-1:0]    upper_last_rgb;
  logic [SPAN_W-1:0]             span_ticks;
  logic [bpcg_pkg::OFFSET_W-1:0] phase_offset_ticks;
  logic [PH_W-1:0]               phase_step;

  // Write registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_first_rgb    <= bpcg_pkg::RST_LOWER_RGB;
      lower_last_rgb     <= bpcg_pkg::RST_LOWER_RGB;
      upper_first_rgb    <= bpcg_pkg::RST_UPPER_RGB;
      upper_last_rgb     <= bpcg_pkg::RST_UPPER_RGB;
      span_ticks         <= bpcg_pkg::RST_SPAN;
      phase_offset_ticks <= bpcg_pkg::RST_OFFSET;
      phase_step         <= bpcg_pkg::RST_STEP;
    end else if (cfg_we) begin
      case (bpcg_pkg::cfg_reg_t'(cfg_index))
        bpcg_pkg::REG_LOWER_FIRST: lower_first_rgb    <= cfg_data;
        bpcg_pkg::REG_LOWER_LAST:  lower_last_rgb     <= cfg_data;
        bpcg_pkg::REG_UPPER_FIRST: upper_first_rgb    <= cfg_data;
        bpcg_pkg::REG_UPPER_LAST:  upper_last_rgb     <= cfg_data;
        bpcg_pkg::REG_SPAN:        span_ticks         <= cfg_data[SPAN_W-1:0];
        bpcg_pkg::REG_OFFSET:      phase_offset_ticks <= cfg_data[bpcg_pkg::OFFSET_W-1:0];
        bpcg_pkg::REG_STEP:        phase_step         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance
  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  // A stage loads when it is empty or its beat moves on
  always_comb begin
    adv[NS-1] = !vld[NS-1] || color_out.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign time_in.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= time_in.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 0: saturation test, divider seed, phase delta
  logic [WIDE_W-1:0] t_wide;
  logic [WIDE_W-1:0] span_wide;
  logic              in_sat;
  logic [PH_W-1:0]   in_delta;

  assign t_wide    = WIDE_W'(time_in.time_ticks);
  assign span_wide = WIDE_W'(span_ticks);
  assign in_sat    = (span_ticks == '0) || (t_wide >= span_wide);
  assign in_delta  = t_wide[PH_W-1:0] -
                     {{(PH_W - bpcg_pkg::OFFSET_W){phase_offset_ticks[bpcg_pkg::OFFSET_W-1]}},
                      phase_offset_ticks};

  logic [SPAN_W-1:0]          div_rem [DIV_END+1];
  logic [bpcg_pkg::FRAC_BITS-1:0] div_q [1:DIV_END];
  logic                       div_sat [DIV_END+1];
  logic [PH_W-1:0]            delta;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      div_rem[0] <= t_wide[SPAN_W-1:0];
      div_sat[0] <= in_sat;
      delta      <= in_delta;
    end
  end

  // Stage 1 phase and stage 2 sine lookup
  logic [PH_W-1:0]    phase_prod;
  logic [PH_W-1:0]    phase;
  logic [1:0]         quad;
  logic [AW-1:0]      quarter_idx;
  logic [AW-1:0]      rom_addr;
  logic [SW-1:0]      rom_data;
  logic               sin_neg [2:DIV_END];
  logic [SW-1:0]      sin_mag [3:DIV_END];

  // Keep only the phase bits modulo one turn
  assign phase_prod  = delta * phase_step;
  assign quad        = phase[PH_W-1 -: 2];
  assign quarter_idx = AW'(phase[PH_W-3 -: SINE_TABLE_BITS]);
  // Odd quadrants mirror the quarter wave
  assign rom_addr    = quad[0] ? (AW'(FULL) - quarter_idx) : quarter_idx;

  bpcg_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk   (clk),
    .rd_en (adv[2]),
    .addr  (rom_addr),
    .data  (rom_data)
  );

  // Divider stages: one quotient bit each, sine beat travels alongside
  for (genvar gs = 1; gs <= DIV_END; gs++) begin : g_div
    logic [SPAN_W:0] rem2;
    logic [SPAN_W:0] rem_sub;
    logic            ge;

    assign rem2    = {div_rem[gs-1], 1'b0};
    assign rem_sub = rem2 - {1'b0, span_ticks};
    assign ge      = rem2 >= {1'b0, span_ticks};

    always_ff @(posedge clk) begin
      if (adv[gs]) begin
        div_rem[gs] <= ge ? rem_sub[SPAN_W-1:0] : rem2[SPAN_W-1:0];
        div_sat[gs] <= div_sat[gs-1];
      end
    end

    if (gs == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (adv[gs]) begin
          div_q[gs] <= {{(bpcg_pkg::FRAC_BITS-1){1'b0}}, ge};
          phase     <= phase_prod;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv[gs]) begin
          div_q[gs] <= {div_q[gs-1][bpcg_pkg::FRAC_BITS-2:0], ge};
        end
      end
    end

    if (gs == 2) begin : g_sign
      always_ff @(posedge clk) begin
        if (adv[gs]) begin
          sin_neg[gs] <= quad[1];
        end
      end
    end else if (gs == 3) begin : g_mag_first
      always_ff @(posedge clk) begin
        if (adv[gs]) begin
          sin_neg[gs] <= sin_neg[gs-1];
          sin_mag[gs] <= rom_data;
        end
      end
    end else if (gs > 3) begin : g_mag_next
      always_ff @(posedge clk) begin
        if (adv[gs]) begin
          sin_neg[gs] <= sin_neg[gs-1];
          sin_mag[gs] <= sin_mag[gs-1];
        end
      end
    end
  end

  // Bound stage: blend first to last per channel
  logic [bpcg_pkg::FRAC_BITS:0] frac;
  logic [7:0]  up_next [3];
  logic [7:0]  lo_next [3];
  logic [7:0]  up_bnd  [3];
  logic [7:0]  lo_bnd  [3];
  logic        bnd_neg;
  logic [SW-1:0] bnd_mag;

  assign frac = div_sat[DIV_END] ? (bpcg_pkg::FRAC_BITS+1)'(1 << bpcg_pkg::FRAC_BITS)
                                 : {1'b0, div_q[DIV_END]};

  always_comb begin
    logic [7:0]  f, l, dmag, m;
    logic        dneg;
    logic [24:0] prod;
    for (int c = 0; c < 3; c++) begin
      // Upper bound
      f    = upper_first_rgb[16 - 8*c +: 8];
      l    = upper_last_rgb[16 - 8*c +: 8];
      dneg = l < f;
      dmag = dneg ? (f - l) : (l - f);
      prod = frac * {9'd0, dmag};
      m    = prod[23:16];
      up_next[c] = dneg ? (f - m) : (f + m);
      // Lower bound
      f    = lower_first_rgb[16 - 8*c +: 8];
      l    = lower_last_rgb[16 - 8*c +: 8];
      dneg = l < f;
      dmag = dneg ? (f - l) : (l - f);
      prod = frac * {9'd0, dmag};
      m    = prod[23:16];
      lo_next[c] = dneg ? (f - m) : (f + m);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[bpcg_pkg::ST_BOUND]) begin
      up_bnd  <= up_next;
      lo_bnd  <= lo_next;
      bnd_neg <= sin_neg[DIV_END];
      bnd_mag <= sin_mag[DIV_END];
    end
  end

  // Mix stage: mean, half difference and the sine product
  logic [7:0] mean_next [3];
  logic [6:0] pm_next   [3];
  logic       pneg_next [3];
  logic [7:0] mean      [3];
  logic [6:0] pm        [3];
  logic       pneg      [3];

  always_comb begin
    logic [8:0]  sum9;
    logic        hneg;
    logic [7:0]  dmag;
    logic [21:0] prod;
    for (int c = 0; c < 3; c++) begin
      sum9         = {1'b0, up_bnd[c]} + {1'b0, lo_bnd[c]};
      mean_next[c] = sum9[8:1];
      hneg         = up_bnd[c] < lo_bnd[c];
      dmag         = hneg ? (lo_bnd[c] - up_bnd[c]) : (up_bnd[c] - lo_bnd[c]);
      prod         = {7'd0, bnd_mag} * {15'd0, dmag[7:1]};
      pm_next[c]   = prod[21:15];
      pneg_next[c] = bnd_neg ^ hneg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[bpcg_pkg::ST_MIX]) begin
      mean <= mean_next;
      pm   <= pm_next;
      pneg <= pneg_next;
    end
  end

  // Output stage: add and clamp to 0..255
  logic [7:0] chan_next [3];
  logic [7:0] chan      [3];

  always_comb begin
    logic [9:0] val;
    for (int c = 0; c < 3; c++) begin
      val = pneg[c] ? ({2'b00, mean[c]} - {3'b000, pm[c]})
                    : ({2'b00, mean[c]} + {3'b000, pm[c]});
      if (val[9]) begin
        chan_next[c] = 8'd0;
      end else if (val[8]) begin
        chan_next[c] = 8'd255;
      end else begin
        chan_next[c] = val[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[bpcg_pkg::ST_OUT]) begin
      chan <= chan_next;
    end
  end

  assign color_out.valid     = vld[bpcg_pkg::ST_OUT];
  assign color_out.red_out   = chan[0];
  assign color_out.green_out = chan[1];
  assign color_out.blue_out  = chan[2];

  // Checks
  logic in_acc;
  logic out_acc;

  assign in_acc  = time_in.valid && time_in.ready;
  assign out_acc = color_out.valid && color_out.ready;

  // Input stalls only when every stage holds a beat
  a_full_on_stall: assert property (@(posedge clk) disable iff (rst)
    !time_in.ready |-> (vld == {NS{1'b1}}))
    else $error("input stalled with a bubble in the pipeline");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

  // Beats in flight change only by accepts and deliveries
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    !rst |=> ($countones(vld) ==
              $past($countones(vld)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("beat lost or duplicated in the pipeline");

endmodule

[tb/sv/bpcg_color_checker.sv]
// Color checker: tracks register writes, predicts each color beat and compares it with the DUT.
`timescale 1ns / 1ps

module bpcg_color_checker #(
  parameter int TIME_BITS       = 20,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bpcg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpcg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             time_valid,
  input  logic                             time_ready,
  input  logic [TIME_BITS-1:0]             time_ticks,
  input  logic                             color_valid,
  input  logic                             color_ready,
  input  logic [7:0]                       red,
  input  logic [7:0]                       green,
  input  logic [7:0]                       blue,
  output int                               mismatches,
  output int                               pending,
  output int                               checked
);

  localparam int SINE_FULL   = 1 << SINE_TABLE_BITS;
  localparam int MAX_REPORTS = 30;
  localparam int RGB_W       = bpcg_pkg::RGB_W;
  localparam int SPAN_W      = bpcg_pkg::SPAN_W;
  localparam int OFFSET_W    = bpcg_pkg::OFFSET_W;
  localparam int PHASE_W     = bpcg_pkg::PHASE_W;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // Shadow copy of the register file
  logic [RGB_W-1:0]    lower_first;
  logic [RGB_W-1:0]    lower_last;
  logic [RGB_W-1:0]    upper_first;
  logic [RGB_W-1:0]    upper_last;
  logic [SPAN_W-1:0]   span;
  logic [OFFSET_W-1:0] offset;
  logic [PHASE_W-1:0]  step;

  int     sine_lut [0:SINE_FULL];
  color_t expected_colors [$];

  // Quarter-wave sine magnitude in unsigned Q0.15 from an eleven-term Taylor series in Q30
  function automatic int quarter_sine(input int i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] rounded;
    x    = (64'(i) * bpcg_pkg::HALF_PI_Q30) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    rounded = (acc + 64'd16384) >> 15;
    return (rounded > 64'd32767) ? 32767 : int'(rounded);
  endfunction

  // Product shifted right with truncation toward zero
  function automatic int scale_trunc(input int a, input int b, input int sh);
    logic   neg;
    longint ma;
    longint mb;
    longint m;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -longint'(a) : longint'(a);
    mb  = (b < 0) ? -longint'(b) : longint'(b);
    m   = (ma * mb) >> sh;
    return neg ? -int'(m) : int'(m);
  endfunction

  // Bound channel moved from its first toward its last value by frac
  function automatic int blend(input logic [RGB_W-1:0] first, input logic [RGB_W-1:0] last,
                               input int sh, input int frac);
    int f;
    int d;
    f = int'((first >> sh) & 24'hFF);
    d = int'((last >> sh) & 24'hFF) - f;
    return f + scale_trunc(frac, d, 16);
  endfunction

  function automatic color_t predict_color(input logic [TIME_BITS-1:0] t);
    logic [TIME_BITS+15:0] quotient;
    logic [63:0]           delta;
    logic [63:0]           offset64;
    logic [63:0]           product;
    logic [PHASE_W-1:0]    phase;
    logic [1:0]            quad;
    int                    idx;
    int                    frac;
    int                    sine;
    int                    up;
    int                    lo;
    int                    mean;
    int                    half;
    int                    level;
    logic [7:0]            chan [0:2];
    // Fraction of the span, saturated at one
    if (span == '0 || t >= span) begin
      frac = 65536;
    end else begin
      quotient = {t, 16'd0} / span;
      frac = int'(quotient);
    end
    // Phase in 2^-24 turns, offset taken as signed
    offset64 = {{(64-OFFSET_W){offset[OFFSET_W-1]}}, offset};
    delta    = 64'(t) - offset64;
    product  = delta * 64'(step);
    phase    = product[PHASE_W-1:0];
    quad     = phase[23:22];
    idx      = int'(phase[21 -: SINE_TABLE_BITS]);
    sine     = quad[0] ? sine_lut[SINE_FULL - idx] : sine_lut[idx];
    if (quad[1]) sine = -sine;
    // Mix each channel around the mean of its bounds
    for (int c = 0; c < 3; c++) begin
      up    = blend(upper_first, upper_last, 16 - 8 * c, frac);
      lo    = blend(lower_first, lower_last, 16 - 8 * c, frac);
      mean  = (up + lo) / 2;
      half  = (up - lo) / 2;
      level = mean + scale_trunc(sine, half, 15);
      if (level < 0) level = 0;
      if (level > 255) level = 255;
      chan[c] = level[7:0];
    end
    return '{red: chan[0], green: chan[1], blue: chan[2]};
  endfunction

  task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
    for (int i = 0; i <= SINE_FULL; i++) sine_lut[i] = quarter_sine(i);
  end

  // Track writes, queue predictions and compare color beats
  always @(posedge clk) begin
    color_t want;
    color_t got;
    if (rst) begin
      lower_first = bpcg_pkg::RST_LOWER_RGB;
      lower_last  = bpcg_pkg::RST_LOWER_RGB;
      upper_first = bpcg_pkg::RST_UPPER_RGB;
      upper_last  = bpcg_pkg::RST_UPPER_RGB;
      span        = bpcg_pkg::RST_SPAN;
      offset      = bpcg_pkg::RST_OFFSET;
      step        = bpcg_pkg::RST_STEP;
      expected_colors.delete();
    end else begin
      if (cfg_we) begin
        case (bpcg_pkg::cfg_reg_t'(cfg_index))
          bpcg_pkg::REG_LOWER_FIRST: lower_first = cfg_data[RGB_W-1:0];
          bpcg_pkg::REG_LOWER_LAST:  lower_last  = cfg_data[RGB_W-1:0];
          bpcg_pkg::REG_UPPER_FIRST: upper_first = cfg_data[RGB_W-1:0];
          bpcg_pkg::REG_UPPER_LAST:  upper_last  = cfg_data[RGB_W-1:0];
          bpcg_pkg::REG_SPAN:        span        = cfg_data[SPAN_W-1:0];
          bpcg_pkg::REG_OFFSET:      offset      = cfg_data[OFFSET_W-1:0];
          bpcg_pkg::REG_STEP:        step        = cfg_data[PHASE_W-1:0];
          default: ;
        endcase
      end
      if (color_valid && color_ready) begin
        got = '{red: red, green: green, blue: blue};
        if (expected_colors.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected color beat, expected none, actual %0d/%0d/%0d",
                     $time, red, green, blue);
        end else begin
          want = expected_colors.pop_front();
          checked++;
          if (got.red !== want.red) report_field("red", want.red, got.red);
          if (got.green !== want.green) report_field("green", want.green, got.green);
          if (got.blue !== want.blue) report_field("blue", want.blue, got.blue);
        end
      end
      if (time_valid && time_ready) expected_colors.push_back(predict_color(time_ticks));
    end
    pending = expected_colors.size();
  end

endmodule

[tb/sv/bounded_pulse_color_generator_tb.sv]
// Testbench top: clock, reset, register settings, time beats, output backpressure and verdict.
`timescale 1ns / 1ps

module bounded_pulse_color_generator_tb;

  localparam int TIME_BITS       = 20;
  localparam int SINE_TABLE_BITS = 10;
  localparam int ITEM_TARGET     = 1100;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CFG_INDEX_W     = bpcg_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W      = bpcg_pkg::CFG_DATA_W;
  localparam int SPAN_W          = bpcg_pkg::SPAN_W;

  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [TIME_BITS-1:0]   TIME_MAX     = '1;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int pending;
  int checked;
  int beats_sent;
  int settings_used;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;

  logic [SPAN_W-1:0]    span_now;
  logic [TIME_BITS-1:0] tick;

  bpcg_time_if #(.TIME_BITS(TIME_BITS)) time_ch ();
  bpcg_rgb_if                           color_ch ();

  bounded_pulse_color_generator #(
    .TIME_BITS       (TIME_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .time_in   (time_ch),
    .color_out (color_ch)
  );

  bpcg_color_checker #(
    .TIME_BITS       (TIME_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .time_valid  (time_ch.valid),
    .time_ready  (time_ch.ready),
    .time_ticks  (time_ch.time_ticks),
    .color_valid (color_ch.valid),
    .color_ready (color_ch.ready),
    .red         (color_ch.red_out),
    .green       (color_ch.green_out),
    .blue        (color_ch.blue_out),
    .mismatches  (mismatches),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out with %0d color beats outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

  // Stall the color output at random
  initial begin
    color_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      color_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Drive one register write; the caller drops the write enable
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == bpcg_pkg::REG_SPAN) span_now = value[SPAN_W-1:0];
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [23:0] lower_first, input logic [23:0] lower_last,
                               input logic [23:0] upper_first, input logic [23:0] upper_last,
                               input logic [23:0] span, input logic [23:0] offset,
                               input logic [23:0] step);
    write_reg(bpcg_pkg::REG_LOWER_FIRST, lower_first);
    write_reg(bpcg_pkg::REG_LOWER_LAST, lower_last);
    write_reg(bpcg_pkg::REG_UPPER_FIRST, upper_first);
    write_reg(bpcg_pkg::REG_UPPER_LAST, upper_last);
    write_reg(bpcg_pkg::REG_SPAN, span);
    write_reg(bpcg_pkg::REG_OFFSET, offset);
    write_reg(bpcg_pkg::REG_STEP, step);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Send one time beat, with random idle cycles ahead of it
  task automatic send_time(input logic [TIME_BITS-1:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      time_ch.valid <= 1'b0;
      @(negedge clk);
    end
    time_ch.valid      <= 1'b1;
    time_ch.time_ticks <= t;
    @(posedge clk);
    while (!time_ch.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
    // Advance the idle pattern with the beat count
    if (beats_sent >= 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (beats_sent >= ITEM_TARGET / 3) begin
      send_idle_pct = 65;
      recv_idle_pct = 15;
    end
  endtask

  // Hold off until every queued color beat has come back
  task automatic drain();
    time_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [23:0] pick_rgb();
    case ($urandom_range(0, 5))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_span();
    case ($urandom_range(0, 5))
      0:       return 24'd1;
      1:       return 24'h0FFFFF;
      2:       return 24'($urandom_range(1, 64));
      3:       return 24'($urandom_range(1, 4096));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return 24'h080000;
      1:       return 24'h07FFFF;
      2:       return 24'h000000;
      3:       return 24'h0FFFFF - 24'($urandom_range(0, 64));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'h000001 << $urandom_range(0, 23);
      3:       return 24'($urandom_range(1, 4096));
      default: return 24'($urandom);
    endcase
  endfunction

  // Bias ticks toward the ramp and its end
  function automatic logic [TIME_BITS-1:0] pick_tick();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return TIME_MAX;
      2, 3:    return TIME_BITS'($urandom_range(0, span_now));
      4:       return TIME_BITS'(span_now + $urandom_range(0, 2) - 1);
      default: return TIME_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int phase_len;
    int ramp_left;
    time_ch.valid      = 1'b0;
    time_ch.time_ticks = '0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    rst                = 1'b1;
    span_now           = bpcg_pkg::RST_SPAN;
    tick               = '0;
    send_idle_pct      = 15;
    recv_idle_pct      = 65;
    beats_sent         = 0;
    settings_used      = 1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Reset setting: start, end of ramp and the largest tick
    send_time('0);
    send_time(TIME_BITS'(1));
    send_time(TIME_BITS'(bpcg_pkg::RST_SPAN - 1));
    send_time(TIME_BITS'(bpcg_pkg::RST_SPAN));
    send_time(TIME_MAX);
    drain();

    // Inverted bounds, oversized span write that masks to zero, most negative offset,
    // fastest step, and a write to an unmapped index
    write_reg(REG_UNMAPPED, 24'h123456);
    apply_setting(24'hFFFFFF, 24'h00FF00, 24'h000000, 24'h80FF7F,
                  24'hF00000, 24'h080000, 24'hFFFFFF);
    send_time('0);
    send_time(TIME_MAX);
    send_time(TIME_BITS'(20'h80000));
    send_time(TIME_BITS'(20'h5A5A5));
    drain();

    // Shortest span, largest positive offset, frozen phase
    apply_setting(24'h00FF80, 24'hFF0000, 24'hFFFFFF, 24'h0000FF,
                  24'd1, 24'h07FFFF, 24'd0);
    send_time('0);
    send_time(TIME_BITS'(1));
    send_time(TIME_MAX);
    drain();

    // Longest span; one table step per tick walks through all quadrants
    apply_setting(24'h204060, 24'hA0C0E0, 24'hF0E0D0, 24'h102030,
                  24'h0FFFFF, 24'd0, 24'h001000);
    send_time(TIME_BITS'(0));
    send_time(TIME_BITS'(512));
    send_time(TIME_BITS'(1023));
    send_time(TIME_BITS'(1024));
    send_time(TIME_BITS'(1536));
    send_time(TIME_BITS'(2048));
    send_time(TIME_BITS'(2560));
    send_time(TIME_BITS'(3072));
    send_time(TIME_BITS'(4095));
    drain();

    // Random settings, each with a mix of single ticks and running tick ramps
    while (beats_sent < ITEM_TARGET) begin
      apply_setting(pick_rgb(), pick_rgb(), pick_rgb(), pick_rgb(),
                    pick_span(), pick_offset(), pick_step());
      phase_len = $urandom_range(60, 160);
      ramp_left = 0;
      for (int k = 0; k < phase_len; k++) begin
        if (ramp_left > 0) begin
          tick = tick + 1'b1;
          ramp_left--;
        end else begin
          tick = pick_tick();
          if ($urandom_range(0, 3) == 0) ramp_left = $urandom_range(4, 24);
        end
        send_time(tick);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d time beats under %0d register settings; checked %0d color beats",
             beats_sent, settings_used, checked);
    $display("Idle patterns: slow sink, then slow source, then full rate");
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
